@@ hw/rtl/ctc_pkg.sv @@
// Package for the complex transposed convolution block.
// Holds the request codes, register indexes, payload structs and the sequencer states.
// No dependencies.
`default_nettype none
package ctc_pkg;

    localparam int unsigned FIELD_BITS = 16;
    localparam int unsigned ACC_BITS   = 40;
    localparam int unsigned CFG_BITS   = 9;
    localparam int unsigned CFG_IDX_BITS = 3;

    typedef enum logic [1:0] {
        REQ_LOAD_SAMPLE = 2'd0,
        REQ_LOAD_WEIGHT = 2'd1,
        REQ_RUN         = 2'd2,
        REQ_READ        = 2'd3
    } req_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_IN_CHANNELS  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_CHANNELS = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_WIDTH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CONJUGATE    = 3'd5;

    typedef struct packed {
        logic [1:0]                   req_type;
        logic [7:0]                   position;
        logic [2:0]                   tap;
        logic [3:0]                   in_chan;
        logic [3:0]                   out_chan;
        logic signed [FIELD_BITS-1:0] value_re;
        logic signed [FIELD_BITS-1:0] value_im;
    } in_item_t;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] out_re;
        logic signed [ACC_BITS-1:0] out_im;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH,
        ST_MUL,
        ST_SUM,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_READ_WAIT,
        ST_READ_OUT
    } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/ctc_cmac.sv @@
// Shared complex multiply unit: four registered real products, then a registered
// complex sum with optional conjugation of the weight. Uses ctc_pkg.
`default_nettype none
module ctc_cmac
(
    input  wire                                   clk,
    input  wire signed [ctc_pkg::FIELD_BITS-1:0]  u_re,
    input  wire signed [ctc_pkg::FIELD_BITS-1:0]  u_im,
    input  wire signed [ctc_pkg::FIELD_BITS-1:0]  w_re,
    input  wire signed [ctc_pkg::FIELD_BITS-1:0]  w_im,
    input  wire                                   conj,
    output logic signed [ctc_pkg::ACC_BITS-1:0]   p_re,
    output logic signed [ctc_pkg::ACC_BITS-1:0]   p_im
);
    import ctc_pkg::*;

    localparam int unsigned PB = 2 * FIELD_BITS;

    logic signed [PB-1:0] rr_reg, ii_reg, ir_reg, ri_reg;

    // First stage: the four partial products.
    always_ff @(posedge clk)
    begin
        rr_reg <= u_re * w_re;
        ii_reg <= u_im * w_im;
        ir_reg <= u_im * w_re;
        ri_reg <= u_re * w_im;
    end

    // Second stage: combine into a complex product, conjugating the weight if asked.
    always_ff @(posedge clk)
    begin
        if (conj)
        begin
            p_re <= ACC_BITS'(rr_reg) + ACC_BITS'(ii_reg);
            p_im <= ACC_BITS'(ir_reg) - ACC_BITS'(ri_reg);
        end
        else
        begin
            p_re <= ACC_BITS'(rr_reg) - ACC_BITS'(ii_reg);
            p_im <= ACC_BITS'(ir_reg) + ACC_BITS'(ri_reg);
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/complex_transposed_conv_1d.sv @@
// Complex strided transposed 1-D convolution with one shared complex multiplier.
// Loads write on acceptance; a read result follows READ_WAIT and READ_OUT, and the next
// transaction can be accepted the cycle after it is taken. A run zeroes the 4096 accumulators
// (one per cycle), then adds the products over the input channels for each (position,
// channel, tap) into an accumulator. rst_n is asynchronous, active low; after reset the same
// sweep runs before in_ready rises. Sample and weight stores hold garbage until written.
`default_nettype none
module complex_transposed_conv_1d
#(
    parameter int unsigned MAX_IN_CHANNELS  = 16,
    parameter int unsigned MAX_OUT_CHANNELS = 16,
    parameter int unsigned MAX_OUT_WIDTH    = 256,
    parameter int unsigned MAX_KERNEL_WIDTH = 8
)
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire ctc_pkg::in_item_t                in_data,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output ctc_pkg::out_item_t                    out_data,
    input  wire                                   cfg_we,
    input  wire [ctc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  wire [ctc_pkg::CFG_BITS-1:0]           cfg_data
);
    import ctc_pkg::*;

    localparam int unsigned ICB = (MAX_IN_CHANNELS  > 1) ? $clog2(MAX_IN_CHANNELS)  : 1;
    localparam int unsigned OCB = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int unsigned OWB = (MAX_OUT_WIDTH    > 1) ? $clog2(MAX_OUT_WIDTH)    : 1;
    localparam int unsigned KWB = (MAX_KERNEL_WIDTH > 1) ? $clog2(MAX_KERNEL_WIDTH) : 1;
    localparam int unsigned SDEPTH = MAX_OUT_WIDTH * MAX_IN_CHANNELS;
    localparam int unsigned WDEPTH = MAX_KERNEL_WIDTH * MAX_IN_CHANNELS * MAX_OUT_CHANNELS;
    localparam int unsigned ADEPTH = MAX_OUT_WIDTH * MAX_OUT_CHANNELS;
    localparam int unsigned SAB = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int unsigned WAB = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int unsigned AAB = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
    // Counters wide enough to hold the maxima themselves.
    localparam int unsigned ICW = $clog2(MAX_IN_CHANNELS + 1);
    localparam int unsigned OCW = $clog2(MAX_OUT_CHANNELS + 1);
    localparam int unsigned OWW = $clog2(MAX_OUT_WIDTH + 1);
    localparam int unsigned KWW = $clog2(MAX_KERNEL_WIDTH + 1);
    localparam int unsigned PW  = OWW + 4;

    // Configuration registers.
    logic [4:0] in_channels_reg, out_channels_reg;
    logic [8:0] out_width_reg;
    logic [3:0] kernel_width_reg, stride_reg;
    logic       conj_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_channels_reg  <= 5'd1;
            out_channels_reg <= 5'd1;
            out_width_reg    <= 9'd256;
            kernel_width_reg <= 4'd1;
            stride_reg       <= 4'd1;
            conj_reg         <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IN_CHANNELS:  in_channels_reg  <= cfg_data[4:0];
                REG_OUT_CHANNELS: out_channels_reg <= cfg_data[4:0];
                REG_OUT_WIDTH:    out_width_reg    <= cfg_data;
                REG_KERNEL_WIDTH: kernel_width_reg <= cfg_data[3:0];
                REG_STRIDE:       stride_reg       <= cfg_data[3:0];
                REG_CONJUGATE:    conj_reg         <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Saturated run limits.
    logic [ICW-1:0] nic;
    logic [OCW-1:0] noc;
    logic [OWW-1:0] now_lim;
    logic [KWW-1:0] nkw;
    logic [3:0]     nst;

    always_comb
    begin
        nic = (32'(in_channels_reg)  > MAX_IN_CHANNELS)  ? ICW'(MAX_IN_CHANNELS)
                                                         : ICW'(in_channels_reg);
        noc = (32'(out_channels_reg) > MAX_OUT_CHANNELS) ? OCW'(MAX_OUT_CHANNELS)
                                                         : OCW'(out_channels_reg);
        now_lim = (32'(out_width_reg) > MAX_OUT_WIDTH)   ? OWW'(MAX_OUT_WIDTH)
                                                         : OWW'(out_width_reg);
        nkw = (32'(kernel_width_reg) > MAX_KERNEL_WIDTH) ? KWW'(MAX_KERNEL_WIDTH)
                                                         : KWW'(kernel_width_reg);
        nst = (stride_reg == 4'd0) ? 4'd1 : stride_reg;
    end

    // Memories.
    logic [2*FIELD_BITS-1:0] sample_mem [SDEPTH];
    logic [2*FIELD_BITS-1:0] weight_mem [WDEPTH];
    logic [2*ACC_BITS-1:0]   accum_mem  [ADEPTH];

    // Sequencer registers.
    state_t         state_reg, state_next;
    logic [OWW-1:0] ix_reg, ix_next;
    logic [OWW-1:0] base_reg, base_next;
    logic [OCW-1:0] oc_reg, oc_next;
    logic [KWW-1:0] t_reg, t_next;
    logic [ICW-1:0] ic_reg, ic_next;
    logic [AAB-1:0] clr_reg, clr_next;
    logic [1:0]     wait_reg, wait_next;
    logic signed [ACC_BITS-1:0] sum_re_reg, sum_re_next, sum_im_reg, sum_im_next;
    logic [AAB-1:0] ra_reg, ra_next;
    logic           rzero_reg, rzero_next;
    logic           out_valid_reg, out_valid_next;

    // Memory read data and addresses.
    logic [2*FIELD_BITS-1:0] s_rd_reg, w_rd_reg;
    logic [2*ACC_BITS-1:0]   a_rd_reg;
    logic [SAB-1:0] s_addr;
    logic [WAB-1:0] w_addr;
    logic [AAB-1:0] a_addr_run;
    logic           a_we;
    logic [AAB-1:0] a_waddr;
    logic [2*ACC_BITS-1:0] a_wdata;

    logic signed [ACC_BITS-1:0] p_re, p_im;

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    // Run address generation.
    logic [PW-1:0] op;
    always_comb
    begin
        op = PW'(base_reg) + PW'(t_reg);
        s_addr = SAB'(ix_reg[OWB-1:0]) * SAB'(MAX_IN_CHANNELS) + SAB'(ic_reg[ICB-1:0]);
        w_addr = (WAB'(t_reg[KWB-1:0]) * WAB'(MAX_IN_CHANNELS) + WAB'(ic_reg[ICB-1:0]))
                 * WAB'(MAX_OUT_CHANNELS) + WAB'(oc_reg[OCB-1:0]);
        a_addr_run = AAB'(op[OWB-1:0]) * AAB'(MAX_OUT_CHANNELS) + AAB'(oc_reg[OCB-1:0]);
    end

    // Sample and weight stores: written by load transactions, read by the run loop.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.req_type == REQ_LOAD_SAMPLE
            && 32'(in_data.position) < MAX_OUT_WIDTH
            && 32'(in_data.in_chan) < MAX_IN_CHANNELS)
        begin
            sample_mem[SAB'(in_data.position) * SAB'(MAX_IN_CHANNELS)
                       + SAB'(in_data.in_chan)] <= {in_data.value_re, in_data.value_im};
        end
        s_rd_reg <= sample_mem[s_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.req_type == REQ_LOAD_WEIGHT
            && 32'(in_data.tap) < MAX_KERNEL_WIDTH
            && 32'(in_data.in_chan) < MAX_IN_CHANNELS
            && 32'(in_data.out_chan) < MAX_OUT_CHANNELS)
        begin
            weight_mem[(WAB'(in_data.tap) * WAB'(MAX_IN_CHANNELS) + WAB'(in_data.in_chan))
                       * WAB'(MAX_OUT_CHANNELS) + WAB'(in_data.out_chan)]
                <= {in_data.value_re, in_data.value_im};
        end
        w_rd_reg <= weight_mem[w_addr];
    end

    // Accumulator memory: one write port, one read port.
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            accum_mem[a_waddr] <= a_wdata;
        end
        a_rd_reg <= accum_mem[(state_reg == ST_READ_WAIT) ? ra_reg : a_addr_run];
    end

    ctc_cmac u_cmac
    (
        .clk  (clk),
        .u_re (s_rd_reg[2*FIELD_BITS-1:FIELD_BITS]),
        .u_im (s_rd_reg[FIELD_BITS-1:0]),
        .w_re (w_rd_reg[2*FIELD_BITS-1:FIELD_BITS]),
        .w_im (w_rd_reg[FIELD_BITS-1:0]),
        .conj (conj_reg),
        .p_re (p_re),
        .p_im (p_im)
    );

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
            ix_reg        <= '0;
            base_reg      <= '0;
            oc_reg        <= '0;
            t_reg         <= '0;
            ic_reg        <= '0;
            clr_reg       <= '0;
            wait_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ix_reg        <= ix_next;
            base_reg      <= base_next;
            oc_reg        <= oc_next;
            t_reg         <= t_next;
            ic_reg        <= ic_next;
            clr_reg       <= clr_next;
            wait_reg      <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_re_reg <= sum_re_next;
        sum_im_reg <= sum_im_next;
        ra_reg     <= ra_next;
        rzero_reg  <= rzero_next;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ_OUT)
        begin
            out_data.out_re <= rzero_reg ? '0 : a_rd_reg[2*ACC_BITS-1:ACC_BITS];
            out_data.out_im <= rzero_reg ? '0 : a_rd_reg[ACC_BITS-1:0];
        end
    end

    assign out_valid = out_valid_reg;

    // Next state and datapath control.
    logic [PW-1:0] next_end;
    always_comb
    begin
        state_next     = state_reg;
        ix_next        = ix_reg;
        base_next      = base_reg;
        oc_next        = oc_reg;
        t_next         = t_reg;
        ic_next        = ic_reg;
        clr_next       = clr_reg;
        wait_next      = wait_reg;
        sum_re_next    = sum_re_reg;
        sum_im_next    = sum_im_reg;
        ra_next        = ra_reg;
        rzero_next     = rzero_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        a_we           = 1'b0;
        a_waddr        = a_addr_run;
        a_wdata        = {sum_re_reg, sum_im_reg};
        next_end       = PW'(base_reg) + PW'(nst) + PW'(nkw);

        unique case (state_reg)
            // Zero the accumulators once after reset.
            ST_INIT:
            begin
                a_we     = 1'b1;
                a_waddr  = clr_reg;
                a_wdata  = '0;
                clr_next = clr_reg + AAB'(1);
                if (32'(clr_reg) == ADEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = !out_valid_reg;
                if (in_valid && in_ready)
                begin
                    unique case (in_data.req_type)
                        REQ_RUN:
                        begin
                            clr_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        REQ_READ:
                        begin
                            rzero_next = !(32'(in_data.position) < MAX_OUT_WIDTH
                                           && 32'(in_data.out_chan) < MAX_OUT_CHANNELS);
                            ra_next = AAB'(in_data.position[OWB-1:0]) * AAB'(MAX_OUT_CHANNELS)
                                      + AAB'(in_data.out_chan[OCB-1:0]);
                            state_next = ST_READ_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                a_we    = 1'b1;
                a_waddr = clr_reg;
                a_wdata = '0;
                clr_next = clr_reg + AAB'(1);
                if (32'(clr_reg) == ADEPTH - 1)
                begin
                    ix_next = '0;
                    base_next = '0;
                    oc_next = '0;
                    t_next  = '0;
                    ic_next = '0;
                    if (PW'(nkw) <= PW'(now_lim) && noc != '0)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            // Walk input channels: issue reads, then wait for the multiplier.
            ST_FETCH:
            begin
                sum_re_next = '0;
                sum_im_next = '0;
                wait_next   = '0;
                if (nic == '0)
                begin
                    state_next = ST_ACC_RD;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // The wait covers the memory read and both multiplier stages.
                wait_next = wait_reg + 2'd1;
                if (wait_reg == 2'd3)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_re_next = sum_re_reg + p_re;
                sum_im_next = sum_im_reg + p_im;
                wait_next   = '0;
                if (ic_reg + ICW'(1) == nic)
                begin
                    ic_next = '0;
                    state_next = ST_ACC_RD;
                end
                else
                begin
                    ic_next = ic_reg + ICW'(1);
                    state_next = ST_MUL;
                end
            end
            ST_ACC_RD:
            begin
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                a_we    = 1'b1;
                a_wdata = {sum_re_reg + $signed(a_rd_reg[2*ACC_BITS-1:ACC_BITS]),
                           sum_im_reg + $signed(a_rd_reg[ACC_BITS-1:0])};
                state_next = ST_FETCH;
                if (t_reg + KWW'(1) != nkw)
                begin
                    t_next = t_reg + KWW'(1);
                end
                else
                begin
                    t_next = '0;
                    if (oc_reg + OCW'(1) != noc)
                    begin
                        oc_next = oc_reg + OCW'(1);
                    end
                    else
                    begin
                        oc_next = '0;
                        if (next_end <= PW'(now_lim)
                            && 32'(ix_reg) + 1 < MAX_OUT_WIDTH)
                        begin
                            ix_next   = ix_reg + OWW'(1);
                            base_next = OWW'(PW'(base_reg) + PW'(nst));
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_READ_OUT;
            end
            ST_READ_OUT:
            begin
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // No new transaction is taken while a result waits.
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while result pending");

    // A result follows every accepted read, after the READ_WAIT and READ_OUT states.
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.req_type == REQ_READ) |-> ##3 out_valid)
        else $error("read produced no result");

    // The clear sweep never writes past the accumulator memory.
    a_clear_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_INIT) |-> (32'(clr_reg) < ADEPTH))
        else $error("clear sweep out of range");
`endif

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the complex transposed 1-D convolution block.
// Uses ctc_pkg for the payload structs, request codes and register indexes.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import ctc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 200000;
    localparam int unsigned TARGET_ITEMS   = 1800;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    in_item_t                in_data = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    out_item_t               out_data;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data = '0;

    complex_transposed_conv_1d u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the block: stores, accumulators and registers.
    logic signed [15:0] smp_re [256][16];
    logic signed [15:0] smp_im [256][16];
    bit                 smp_written [256][16];
    logic signed [15:0] wgt_re [8][16][16];
    logic signed [15:0] wgt_im [8][16][16];
    bit                 wgt_written [8][16][16];
    logic [39:0]        acc_re [256][16];
    logic [39:0]        acc_im [256][16];
    logic [4:0]         r_in_ch = 5'd1;
    logic [4:0]         r_out_ch = 5'd1;
    logic [8:0]         r_out_w = 9'd256;
    logic [3:0]         r_kern_w = 4'd1;
    logic [3:0]         r_stride = 4'd1;
    logic               r_conj = 1'b0;

    out_item_t pending_outputs [$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        items_sent = 0;
    int        outputs_checked = 0;
    int        mismatches = 0;
    int        runs_done = 0;
    int        phases_done = 0;
    int        quiet_cycles = 0;

    // Effective register values after saturation and stride-zero handling.
    function automatic int eff_nic();
        return (r_in_ch > 16) ? 16 : int'(r_in_ch);
    endfunction

    function automatic int eff_noc();
        return (r_out_ch > 16) ? 16 : int'(r_out_ch);
    endfunction

    function automatic int eff_ow();
        return (r_out_w > 256) ? 256 : int'(r_out_w);
    endfunction

    function automatic int eff_kw();
        return (r_kern_w > 8) ? 8 : int'(r_kern_w);
    endfunction

    function automatic int eff_st();
        return (r_stride == 0) ? 1 : int'(r_stride);
    endfunction

    // Number of input positions that a run processes.
    function automatic int active_positions();
        int ix;
        ix = 0;
        while (ix * eff_st() + eff_kw() <= eff_ow() && ix < 256)
            ix++;
        return ix;
    endfunction

    // Transposed convolution over the shadow stores into the shadow accumulators.
    task automatic compute_accumulators();
        longint ur, ui, wr, wi, rr, ii, ir, ri;
        int     op;
        for (int p = 0; p < 256; p++)
            for (int c = 0; c < 16; c++)
            begin
                acc_re[p][c] = '0;
                acc_im[p][c] = '0;
            end
        for (int ix = 0; ix < active_positions(); ix++)
            for (int oc = 0; oc < eff_noc(); oc++)
                for (int t = 0; t < eff_kw(); t++)
                begin
                    op = ix * eff_st() + t;
                    for (int ic = 0; ic < eff_nic(); ic++)
                    begin
                        ur = smp_re[ix][ic];
                        ui = smp_im[ix][ic];
                        wr = wgt_re[t][ic][oc];
                        wi = wgt_im[t][ic][oc];
                        rr = ur * wr;
                        ii = ui * wi;
                        ir = ui * wr;
                        ri = ur * wi;
                        if (r_conj)
                        begin
                            acc_re[op][oc] += 40'(rr + ii);
                            acc_im[op][oc] += 40'(ir - ri);
                        end
                        else
                        begin
                            acc_re[op][oc] += 40'(rr - ii);
                            acc_im[op][oc] += 40'(ir + ri);
                        end
                    end
                end
    endtask

    // Update the shadow state for one transaction and queue any expected output.
    task automatic predict_item(in_item_t it, bit known, logic [39:0] k_re, logic [39:0] k_im);
        out_item_t o;
        case (req_t'(it.req_type))
            REQ_LOAD_SAMPLE:
            begin
                smp_re[it.position][it.in_chan] = it.value_re;
                smp_im[it.position][it.in_chan] = it.value_im;
                smp_written[it.position][it.in_chan] = 1'b1;
            end
            REQ_LOAD_WEIGHT:
            begin
                wgt_re[it.tap][it.in_chan][it.out_chan] = it.value_re;
                wgt_im[it.tap][it.in_chan][it.out_chan] = it.value_im;
                wgt_written[it.tap][it.in_chan][it.out_chan] = 1'b1;
            end
            REQ_RUN:
            begin
                compute_accumulators();
                runs_done++;
            end
            default:
            begin
                o.out_re = acc_re[it.position][it.out_chan];
                o.out_im = acc_im[it.position][it.out_chan];
                if (known)
                begin
                    o.out_re = k_re;
                    o.out_im = k_im;
                end
                pending_outputs.push_back(o);
            end
        endcase
    endtask

    // Drive one transaction and hold it until the block takes it.
    task automatic send_item(in_item_t it, bit known = 1'b0,
                             logic [39:0] k_re = '0, logic [39:0] k_im = '0);
        predict_item(it, known, k_re, k_im);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    function automatic in_item_t make_item(req_t rq, int pos, int tp, int ic, int oc,
                                           int vre, int vim);
        in_item_t it;
        it.req_type = rq;
        it.position = 8'(pos);
        it.tap      = 3'(tp);
        it.in_chan  = 4'(ic);
        it.out_chan = 4'(oc);
        it.value_re = 16'(vre);
        it.value_im = 16'(vim);
        return it;
    endfunction

    // Random Q1.15 value, with the extremes and zero showing up often.
    function automatic int rand_value();
        case ($urandom_range(7))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // Hold the sender until every expected output has arrived and the block is quiet.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_config(int nic, int noc, int ow, int kw, int st, int cj);
        logic [CFG_BITS-1:0] vals [6];
        logic [CFG_IDX_BITS-1:0] idx [6];
        vals = '{9'(nic), 9'(noc), 9'(ow), 9'(kw), 9'(st), 9'(cj)};
        idx  = '{REG_IN_CHANNELS, REG_OUT_CHANNELS, REG_OUT_WIDTH,
                 REG_KERNEL_WIDTH, REG_STRIDE, REG_CONJUGATE};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        r_in_ch  = 5'(nic);
        r_out_ch = 5'(noc);
        r_out_w  = 9'(ow);
        r_kern_w = 4'(kw);
        r_stride = 4'(st);
        r_conj   = 1'(cj);
    endtask

    // Load every sample and weight that the next run touches and that is still unwritten,
    // then start the run.
    task automatic fill_and_run();
        for (int ix = 0; ix < active_positions(); ix++)
            for (int ic = 0; ic < eff_nic(); ic++)
                if (!smp_written[ix][ic])
                    send_item(make_item(REQ_LOAD_SAMPLE, ix, $urandom_range(7), ic,
                                        $urandom_range(15), rand_value(), rand_value()));
        if (active_positions() > 0)
            for (int t = 0; t < eff_kw(); t++)
                for (int ic = 0; ic < eff_nic(); ic++)
                    for (int oc = 0; oc < eff_noc(); oc++)
                        if (!wgt_written[t][ic][oc])
                            send_item(make_item(REQ_LOAD_WEIGHT, $urandom_range(255), t, ic,
                                                oc, rand_value(), rand_value()));
        send_item(make_item(REQ_RUN, $urandom_range(255), $urandom_range(7),
                            $urandom_range(15), $urandom_range(15), rand_value(),
                            rand_value()));
    endtask

    task automatic random_load();
        int span;
        span = active_positions() > 0 ? active_positions() : 1;
        if ($urandom_range(1))
            send_item(make_item(REQ_LOAD_SAMPLE,
                                ($urandom_range(3) != 0) ? $urandom_range(span - 1)
                                                         : $urandom_range(255),
                                $urandom_range(7), $urandom_range(15), $urandom_range(15),
                                rand_value(), rand_value()));
        else
            send_item(make_item(REQ_LOAD_WEIGHT, $urandom_range(255), $urandom_range(7),
                                $urandom_range(15), $urandom_range(15), rand_value(),
                                rand_value()));
    endtask

    task automatic random_read();
        int pos;
        pos = ($urandom_range(3) != 0) ? $urandom_range(eff_ow() - 1) : $urandom_range(255);
        send_item(make_item(REQ_READ, pos, $urandom_range(7), $urandom_range(15),
                            ($urandom_range(3) != 0) ? $urandom_range(eff_noc() > 0 ?
                                                       eff_noc() - 1 : 0)
                                                     : $urandom_range(15),
                            rand_value(), rand_value()));
    endtask

    // One phase: loads, a run, then mostly reads mixed with loads and further runs.
    task automatic random_phase(int n);
        int r;
        repeat (n / 5) random_load();
        fill_and_run();
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(19);
            if (r < 11)
                random_read();
            else if (r < 19)
                random_load();
            else
                fill_and_run();
        end
        repeat (8) random_read();
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 78; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 78; end
            default: begin send_idle_pct = 33; recv_idle_pct = 33; end
        endcase
    endtask

    // Receiver side: random stalls.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each output transaction with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output re=%0h im=%0h",
                             out_data.out_re, out_data.out_im);
            end
            else
            begin
                want = pending_outputs.pop_front();
                outputs_checked++;
                if (out_data.out_re !== want.out_re || out_data.out_im !== want.out_im)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: output %0d expected re=%0h im=%0h got re=%0h im=%0h",
                                 outputs_checked, want.out_re, want.out_im,
                                 out_data.out_re, out_data.out_im);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TIMEOUT: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    typedef struct {
        in_item_t    it;
        bit          known;
        logic [39:0] k_re;
        logic [39:0] k_im;
    } directed_row_t;

    initial
    begin
        directed_row_t rows [$];
        int phase_cfg [12][6];

        for (int p = 0; p < 256; p++)
            for (int c = 0; c < 16; c++)
            begin
                smp_written[p][c] = 1'b0;
                acc_re[p][c] = '0;
                acc_im[p][c] = '0;
            end
        for (int t = 0; t < 8; t++)
            for (int i = 0; i < 16; i++)
                for (int o = 0; o < 16; o++)
                    wgt_written[t][i][o] = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part: single-tap, single-position setup with extreme operands.
        write_config(1, 1, 1, 1, 1, 0);
        rows.push_back('{make_item(REQ_READ, 0, 0, 0, 0, 0, 0), 1, '0, '0});
        rows.push_back('{make_item(REQ_READ, 255, 7, 15, 15, -1, -1), 1, '0, '0});
        rows.push_back('{make_item(REQ_LOAD_SAMPLE, 0, 0, 0, 0, -32768, -32768), 0, '0, '0});
        rows.push_back('{make_item(REQ_LOAD_WEIGHT, 0, 0, 0, 0, -32768, -32768), 0, '0, '0});
        rows.push_back('{make_item(REQ_RUN, 0, 0, 0, 0, 0, 0), 0, '0, '0});
        rows.push_back('{make_item(REQ_READ, 0, 0, 0, 0, 0, 0), 1, '0, 40'h0080000000});
        // Output outside the processed width and a channel beyond out_channels.
        rows.push_back('{make_item(REQ_READ, 1, 0, 0, 0, 0, 0), 1, '0, '0});
        rows.push_back('{make_item(REQ_READ, 0, 0, 0, 5, 0, 0), 1, '0, '0});
        rows.push_back('{make_item(REQ_LOAD_SAMPLE, 255, 7, 15, 15, 32767, 32767), 0, '0, '0});
        rows.push_back('{make_item(REQ_LOAD_WEIGHT, 255, 7, 15, 15, 32767, -32768), 0, '0, '0});
        rows.push_back('{make_item(REQ_LOAD_SAMPLE, 0, 0, 0, 0, 32767, -32768), 0, '0, '0});
        rows.push_back('{make_item(REQ_LOAD_WEIGHT, 0, 0, 0, 0, 32767, 32767), 0, '0, '0});
        rows.push_back('{make_item(REQ_RUN, 255, 7, 15, 15, -1, -1), 0, '0, '0});
        rows.push_back('{make_item(REQ_READ, 0, 0, 0, 0, 0, 0), 0, '0, '0});
        rows.push_back('{make_item(REQ_READ, 255, 0, 0, 15, 0, 0), 1, '0, '0});
        foreach (rows[i])
            send_item(rows[i].it, rows[i].known, rows[i].k_re, rows[i].k_im);
        wait_drained();

        // Fixed settings covering the register extremes, saturation, stride zero,
        // a kernel wider than the output, and zero channel counts.
        phase_cfg = '{'{16, 1, 4, 1, 1, 1}, '{1, 16, 8, 8, 1, 0}, '{31, 2, 6, 2, 3, 1},
                      '{2, 31, 5, 15, 2, 0}, '{1, 1, 256, 1, 8, 0}, '{1, 1, 511, 2, 0, 1},
                      '{3, 3, 20, 3, 2, 0}, '{4, 4, 32, 4, 1, 1}, '{2, 5, 16, 5, 4, 0},
                      '{0, 3, 10, 2, 1, 1}, '{5, 0, 12, 3, 2, 1}, '{1, 2, 3, 3, 5, 0}};
        foreach (phase_cfg[p])
        begin
            set_idling(p);
            write_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                         phase_cfg[p][3], phase_cfg[p][4], phase_cfg[p][5]);
            random_phase(80);
            wait_drained();
            phases_done++;
        end

        // Random settings with small sizes until the item budget is spent.
        while (items_sent < TARGET_ITEMS)
        begin
            set_idling(phases_done);
            write_config($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(40, 1),
                         $urandom_range(8, 1), $urandom_range(8), $urandom_range(1));
            random_phase(120);
            wait_drained();
            phases_done++;
        end

        in_valid <= 1'b0;
        $display("Sent %0d transactions over %0d settings with %0d runs.",
                 items_sent, phases_done + 1, runs_done);
        $display("Checked %0d outputs, %0d mismatches.", outputs_checked, mismatches);
        if (mismatches == 0 && pending_outputs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
